FILE: sv/tbga_pkg.sv
// ----------------------------------------------------------------------------
// tbga_pkg
// Widths and shared types of the three-body acceleration pipeline.
// ----------------------------------------------------------------------------
package tbga_pkg;

    localparam int POS_W         = 32;           // Q16.16 position / acceleration
    localparam int DIFF_W        = POS_W + 1;    // signed difference
    localparam int MAG_W         = POS_W;        // |difference| < 2^32
    localparam int SQ_W          = 2 * MAG_W + 1; // dx^2 + dy^2
    localparam int RAD_W         = SQ_W + 1;     // radicand padded to even width
    localparam int ROOT_W        = RAD_W / 2;    // floor(sqrt(S))
    localparam int REM_W         = ROOT_W + 2;   // sqrt partial remainder
    localparam int SPLIT_W       = 32;           // low slice of S for the cube product
    localparam int DEN_W         = SQ_W + ROOT_W; // S * r
    localparam int Q_W           = 49;           // pair term magnitude, at most 2^48
    localparam int FRAC_SH       = 48;           // numerator is |d| << 48
    localparam int TERM_W        = Q_W + 1;
    localparam int SUM_W         = 66;           // room for sums and 64-bit limits
    localparam int WORD_BITS_DEF = 32;
    localparam int N_PAIR        = 3;
    localparam int N_TERM        = 2 * N_PAIR;
    localparam int N_ACC         = 6;

    typedef struct packed {
        logic             zero;   // pair coincides
        logic             sx;     // dx negative
        logic [MAG_W-1:0] mx;
        logic             sy;     // dy negative
        logic [MAG_W-1:0] my;
    } pair_side_t;

    typedef struct packed {
        logic zero;
        logic neg;
    } term_side_t;

endpackage

FILE: sv/three_body_gravity_acceleration.sv
// ----------------------------------------------------------------------------
// three_body_gravity_acceleration
// Planar three-body pull (unit masses, G = 1) on Q16.16 positions.
//
//   channel   signals                              handshake
//   input     pos_x1..pos_y3 (6 x 32b signed)      in_valid / in_ready
//   output    acc_x1..acc_y3, coincident,          out_valid / out_ready
//             saturated
//
// One item per cycle sustained while the output is not stalled; the stages
// run front end, square root, cube product, divider, then sum and clip. The
// divider, one quotient bit per stage, sets the depth.
// Reset clears all valid bits; payload registers are not reset.
// The whole pipeline advances on one enable: it holds only while a result
// sits in the output register and out_ready is low.
// ----------------------------------------------------------------------------
module three_body_gravity_acceleration #(
    parameter int WORD_BITS = tbga_pkg::WORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [tbga_pkg::POS_W-1:0]   pos_x1,
    input  logic signed [tbga_pkg::POS_W-1:0]   pos_y1,
    input  logic signed [tbga_pkg::POS_W-1:0]   pos_x2,
    input  logic signed [tbga_pkg::POS_W-1:0]   pos_y2,
    input  logic signed [tbga_pkg::POS_W-1:0]   pos_x3,
    input  logic signed [tbga_pkg::POS_W-1:0]   pos_y3,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [tbga_pkg::POS_W-1:0]   acc_x1,
    output logic signed [tbga_pkg::POS_W-1:0]   acc_y1,
    output logic signed [tbga_pkg::POS_W-1:0]   acc_x2,
    output logic signed [tbga_pkg::POS_W-1:0]   acc_y2,
    output logic signed [tbga_pkg::POS_W-1:0]   acc_x3,
    output logic signed [tbga_pkg::POS_W-1:0]   acc_y3,
    output logic                                coincident,
    output logic                                saturated
);

    localparam int POS_W  = tbga_pkg::POS_W;
    localparam int SQ_W   = tbga_pkg::SQ_W;
    localparam int ROOT_W = tbga_pkg::ROOT_W;
    localparam int DEN_W  = tbga_pkg::DEN_W;
    localparam int Q_W    = tbga_pkg::Q_W;
    localparam int TERM_W = tbga_pkg::TERM_W;
    localparam int SUM_W  = tbga_pkg::SUM_W;
    localparam int N_PAIR = tbga_pkg::N_PAIR;
    localparam int N_TERM = tbga_pkg::N_TERM;
    localparam int N_ACC  = tbga_pkg::N_ACC;

    localparam logic signed [SUM_W-1:0] LIM_HI =
        (SUM_W'(1) << (WORD_BITS - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] LIM_LO = -LIM_HI - SUM_W'(1);
    localparam logic [POS_W-1:0] LIM_HI_OUT = LIM_HI[POS_W-1:0];
    localparam logic [POS_W-1:0] LIM_LO_OUT = LIM_LO[POS_W-1:0];

    // pair p runs from body PA[p] to body PB[p]
    localparam int PA [N_PAIR] = '{0, 0, 1};
    localparam int PB [N_PAIR] = '{1, 2, 2};

    logic en;

    logic signed [POS_W-1:0] bx [N_PAIR];
    logic signed [POS_W-1:0] by [N_PAIR];

    logic                    f_v    [N_PAIR];
    logic [SQ_W-1:0]         f_sq   [N_PAIR];
    tbga_pkg::pair_side_t    f_side [N_PAIR];
    logic                    s_v    [N_PAIR];
    logic [SQ_W-1:0]         s_rad  [N_PAIR];
    logic [ROOT_W-1:0]       s_root [N_PAIR];
    tbga_pkg::pair_side_t    s_side [N_PAIR];
    logic                    c_v    [N_PAIR];
    logic [DEN_W-1:0]        c_den  [N_PAIR];
    tbga_pkg::pair_side_t    c_side [N_PAIR];

    logic [N_TERM-1:0]       d_v;
    logic [Q_W-1:0]          d_q    [N_TERM];
    tbga_pkg::term_side_t    d_side [N_TERM];
    logic signed [SUM_W-1:0] term   [N_TERM];
    logic [N_TERM-1:0]       d_zero;

    logic                    v1_reg, v1_next;
    logic signed [SUM_W-1:0] sum_reg [N_ACC];
    logic signed [SUM_W-1:0] sum_next [N_ACC];
    logic                    coin_reg, coin_next;

    logic                    ov_reg;
    logic [POS_W-1:0]        acc_reg [N_ACC];
    logic [POS_W-1:0]        acc_next [N_ACC];
    logic                    coin_out_reg, sat_reg, sat_next;

    assign en       = !ov_reg || out_ready;
    assign in_ready = en;

    assign bx[0] = pos_x1;
    assign by[0] = pos_y1;
    assign bx[1] = pos_x2;
    assign by[1] = pos_y2;
    assign bx[2] = pos_x3;
    assign by[2] = pos_y3;

    for (genvar p = 0; p < N_PAIR; p++)
    begin : g_pair
        tbga_pkg::term_side_t tx_side, ty_side;

        assign tx_side = '{zero: c_side[p].zero, neg: c_side[p].sx};
        assign ty_side = '{zero: c_side[p].zero, neg: c_side[p].sy};

        tbga_front u_front (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .in_v  (in_valid && in_ready),
            .ax    (bx[PA[p]]),
            .ay    (by[PA[p]]),
            .bx    (bx[PB[p]]),
            .by    (by[PB[p]]),
            .out_v (f_v[p]),
            .sq    (f_sq[p]),
            .side  (f_side[p])
        );

        tbga_isqrt u_isqrt (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_v     (f_v[p]),
            .in_rad   (f_sq[p]),
            .in_side  (f_side[p]),
            .out_v    (s_v[p]),
            .out_rad  (s_rad[p]),
            .out_root (s_root[p]),
            .out_side (s_side[p])
        );

        tbga_cube u_cube (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_v     (s_v[p]),
            .in_rad   (s_rad[p]),
            .in_root  (s_root[p]),
            .in_side  (s_side[p]),
            .out_v    (c_v[p]),
            .out_den  (c_den[p]),
            .out_side (c_side[p])
        );

        tbga_div u_div_x (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_v     (c_v[p]),
            .in_mag   (c_side[p].mx),
            .in_den   (c_den[p]),
            .in_side  (tx_side),
            .out_v    (d_v[2*p]),
            .out_q    (d_q[2*p]),
            .out_side (d_side[2*p])
        );

        tbga_div u_div_y (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_v     (c_v[p]),
            .in_mag   (c_side[p].my),
            .in_den   (c_den[p]),
            .in_side  (ty_side),
            .out_v    (d_v[2*p+1]),
            .out_q    (d_q[2*p+1]),
            .out_side (d_side[2*p+1])
        );
    end

    for (genvar i = 0; i < N_TERM; i++)
    begin : g_term
        logic signed [TERM_W-1:0] mag_s;
        assign mag_s     = {1'b0, d_q[i]};
        assign term[i]   = d_side[i].neg ? -SUM_W'(mag_s) : SUM_W'(mag_s);
        assign d_zero[i] = d_side[i].zero;
    end

    // terms: 0/1 pair 1-2 x/y, 2/3 pair 1-3, 4/5 pair 2-3
    always_comb
    begin
        v1_next     = &d_v;
        coin_next   = |d_zero;
        sum_next[0] =  term[0] + term[2];
        sum_next[1] =  term[1] + term[3];
        sum_next[2] = -term[0] + term[4];
        sum_next[3] = -term[1] + term[5];
        sum_next[4] = -term[2] - term[4];
        sum_next[5] = -term[3] - term[5];
    end

    always_comb
    begin
        sat_next = 1'b0;
        for (int i = 0; i < N_ACC; i++)
        begin
            if (sum_reg[i] > LIM_HI)
            begin
                acc_next[i] = LIM_HI_OUT;
                sat_next    = 1'b1;
            end
            else if (sum_reg[i] < LIM_LO)
            begin
                acc_next[i] = LIM_LO_OUT;
                sat_next    = 1'b1;
            end
            else
            begin
                acc_next[i] = sum_reg[i][POS_W-1:0];
            end
            if (coin_reg)
            begin
                acc_next[i] = '0;
            end
        end
        if (coin_reg)
        begin
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v1_next;
            ov_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg      <= sum_next;
            coin_reg     <= coin_next;
            acc_reg      <= acc_next;
            coin_out_reg <= coin_reg;
            sat_reg      <= sat_next;
        end
    end

    assign out_valid  = ov_reg;
    assign acc_x1     = acc_reg[0];
    assign acc_y1     = acc_reg[1];
    assign acc_x2     = acc_reg[2];
    assign acc_y2     = acc_reg[3];
    assign acc_x3     = acc_reg[4];
    assign acc_y3     = acc_reg[5];
    assign coincident = coin_out_reg;
    assign saturated  = sat_reg;

    // the six divider lanes run in lockstep
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(d_v) == 0) || ($countones(d_v) == N_TERM))
        else $error("divider lanes out of step");

    a_coin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && coincident) |->
        (acc_x1 == '0 && acc_y1 == '0 && acc_x2 == '0 && acc_y2 == '0 &&
         acc_x3 == '0 && acc_y3 == '0 && !saturated))
        else $error("coincident result not cleared");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
        (acc_x1 == LIM_HI_OUT || acc_x1 == LIM_LO_OUT ||
         acc_y1 == LIM_HI_OUT || acc_y1 == LIM_LO_OUT ||
         acc_x2 == LIM_HI_OUT || acc_x2 == LIM_LO_OUT ||
         acc_y2 == LIM_HI_OUT || acc_y2 == LIM_LO_OUT ||
         acc_x3 == LIM_HI_OUT || acc_x3 == LIM_LO_OUT ||
         acc_y3 == LIM_HI_OUT || acc_y3 == LIM_LO_OUT))
        else $error("saturated flag without a clipped value");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while pipeline stalled");

endmodule

FILE: sv/tbga_front.sv
// ----------------------------------------------------------------------------
// tbga_front
// Pair front end: differences, magnitudes, squares and squared distance.
// ----------------------------------------------------------------------------
module tbga_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_v,
    input  logic signed [tbga_pkg::POS_W-1:0]    ax,
    input  logic signed [tbga_pkg::POS_W-1:0]    ay,
    input  logic signed [tbga_pkg::POS_W-1:0]    bx,
    input  logic signed [tbga_pkg::POS_W-1:0]    by,
    output logic                                 out_v,
    output logic [tbga_pkg::SQ_W-1:0]            sq,
    output tbga_pkg::pair_side_t                 side
);

    localparam int DIFF_W = tbga_pkg::DIFF_W;
    localparam int MAG_W  = tbga_pkg::MAG_W;
    localparam int SQ_W   = tbga_pkg::SQ_W;
    localparam int PROD_W = 2 * MAG_W;

    logic [3:0]                v_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic signed [DIFF_W-1:0]  ndx, ndy;
    tbga_pkg::pair_side_t      s2_reg, s3_reg, s4_reg;
    tbga_pkg::pair_side_t      s2_next, s4_next;
    logic [PROD_W-1:0]         px_reg, py_reg;
    logic [SQ_W-1:0]           sq_reg, sq_next;

    assign ndx = -dx_reg;
    assign ndy = -dy_reg;

    always_comb
    begin
        s2_next      = '0;
        s2_next.sx   = dx_reg[DIFF_W-1];
        s2_next.mx   = dx_reg[DIFF_W-1] ? ndx[MAG_W-1:0] : dx_reg[MAG_W-1:0];
        s2_next.sy   = dy_reg[DIFF_W-1];
        s2_next.my   = dy_reg[DIFF_W-1] ? ndy[MAG_W-1:0] : dy_reg[MAG_W-1:0];
        sq_next      = SQ_W'(px_reg) + SQ_W'(py_reg);
        s4_next      = s3_reg;
        s4_next.zero = (sq_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_v};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= DIFF_W'(bx) - DIFF_W'(ax);
            dy_reg <= DIFF_W'(by) - DIFF_W'(ay);
            s2_reg <= s2_next;
            px_reg <= PROD_W'(s2_reg.mx) * PROD_W'(s2_reg.mx);
            py_reg <= PROD_W'(s2_reg.my) * PROD_W'(s2_reg.my);
            s3_reg <= s2_reg;
            sq_reg <= sq_next;
            s4_reg <= s4_next;
        end
    end

    assign out_v = v_reg[3];
    assign sq    = sq_reg;
    assign side  = s4_reg;

endmodule

FILE: sv/tbga_isqrt.sv
// ----------------------------------------------------------------------------
// tbga_isqrt
// Pipelined restoring square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tbga_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_v,
    input  logic [tbga_pkg::SQ_W-1:0]     in_rad,
    input  tbga_pkg::pair_side_t          in_side,
    output logic                          out_v,
    output logic [tbga_pkg::SQ_W-1:0]     out_rad,
    output logic [tbga_pkg::ROOT_W-1:0]   out_root,
    output tbga_pkg::pair_side_t          out_side
);

    localparam int SQ_W   = tbga_pkg::SQ_W;
    localparam int RAD_W  = tbga_pkg::RAD_W;
    localparam int ROOT_W = tbga_pkg::ROOT_W;
    localparam int REM_W  = tbga_pkg::REM_W;
    localparam int T_W    = REM_W + 2;

    logic                   v_reg    [ROOT_W];
    logic [REM_W-1:0]       rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]      root_reg [ROOT_W];
    logic [RAD_W-1:0]       rad_reg  [ROOT_W];
    tbga_pkg::pair_side_t   side_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic                 v_in;
        logic [REM_W-1:0]     rem_in;
        logic [ROOT_W-1:0]    root_in;
        logic [RAD_W-1:0]     rad_in;
        tbga_pkg::pair_side_t side_in;
        logic [T_W-1:0]       t, trial, diff;
        logic                 ge;
        logic [REM_W-1:0]     rem_next;
        logic [ROOT_W-1:0]    root_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_v;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = RAD_W'(in_rad);
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // bring down the next two radicand bits, try (4*root + 1)
        assign t         = {rem_in, rad_in[RAD_W-1-2*k -: 2]};
        assign trial     = {2'b00, root_in, 2'b01};
        assign diff      = t - trial;
        assign ge        = (t >= trial);
        assign rem_next  = ge ? diff[REM_W-1:0] : t[REM_W-1:0];
        assign root_next = {root_in[ROOT_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_v    = v_reg[ROOT_W-1];
    assign out_rad  = rad_reg[ROOT_W-1][SQ_W-1:0];
    assign out_root = root_reg[ROOT_W-1];
    assign out_side = side_reg[ROOT_W-1];

endmodule

FILE: sv/tbga_cube.sv
// ----------------------------------------------------------------------------
// tbga_cube
// Cube term S * r as two partial products, summed in a second stage.
// ----------------------------------------------------------------------------
module tbga_cube (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_v,
    input  logic [tbga_pkg::SQ_W-1:0]     in_rad,
    input  logic [tbga_pkg::ROOT_W-1:0]   in_root,
    input  tbga_pkg::pair_side_t          in_side,
    output logic                          out_v,
    output logic [tbga_pkg::DEN_W-1:0]    out_den,
    output tbga_pkg::pair_side_t          out_side
);

    localparam int SQ_W    = tbga_pkg::SQ_W;
    localparam int ROOT_W  = tbga_pkg::ROOT_W;
    localparam int DEN_W   = tbga_pkg::DEN_W;
    localparam int SPLIT_W = tbga_pkg::SPLIT_W;
    localparam int HI_W    = SQ_W - SPLIT_W;
    localparam int PLO_W   = SPLIT_W + ROOT_W;
    localparam int PHI_W   = HI_W + ROOT_W;

    logic [1:0]             v_reg;
    logic [PLO_W-1:0]       plo_reg;
    logic [PHI_W-1:0]       phi_reg;
    logic [DEN_W-1:0]       den_reg, den_next;
    tbga_pkg::pair_side_t   s1_reg, s2_reg;

    assign den_next = (DEN_W'(phi_reg) << SPLIT_W) + DEN_W'(plo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[0], in_v};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg <= PLO_W'(in_rad[SPLIT_W-1:0]) * PLO_W'(in_root);
            phi_reg <= PHI_W'(in_rad[SQ_W-1:SPLIT_W]) * PHI_W'(in_root);
            s1_reg  <= in_side;
            den_reg <= den_next;
            s2_reg  <= s1_reg;
        end
    end

    assign out_v    = v_reg[1];
    assign out_den  = den_reg;
    assign out_side = s2_reg;

endmodule

FILE: sv/tbga_div.sv
// ----------------------------------------------------------------------------
// tbga_div
// Pipelined restoring divider: (|d| << 48) / (S * r), one quotient bit a stage.
// ----------------------------------------------------------------------------
module tbga_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_v,
    input  logic [tbga_pkg::MAG_W-1:0]    in_mag,
    input  logic [tbga_pkg::DEN_W-1:0]    in_den,
    input  tbga_pkg::term_side_t          in_side,
    output logic                          out_v,
    output logic [tbga_pkg::Q_W-1:0]      out_q,
    output tbga_pkg::term_side_t          out_side
);

    localparam int MAG_W = tbga_pkg::MAG_W;
    localparam int DEN_W = tbga_pkg::DEN_W;
    localparam int Q_W   = tbga_pkg::Q_W;

    logic                   v_reg    [Q_W];
    logic [DEN_W-1:0]       rem_reg  [Q_W];
    logic [DEN_W-1:0]       den_reg  [Q_W];
    logic [Q_W-1:0]         q_reg    [Q_W];
    tbga_pkg::term_side_t   side_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic                 v_in;
        logic [DEN_W-1:0]     rem_in;
        logic [DEN_W-1:0]     den_in;
        logic [Q_W-1:0]       q_in;
        tbga_pkg::term_side_t side_in;
        logic                 nbit;
        logic [DEN_W:0]       t, diff;
        logic                 ge;
        logic [DEN_W-1:0]     rem_next;
        logic [Q_W-1:0]       q_next;

        if (k == 0)
        begin : g_first
            // numerator bits above the quotient window are |d| >> 1;
            // the lowest magnitude bit enters here, zeros after
            assign v_in    = in_v;
            assign rem_in  = DEN_W'(in_mag[MAG_W-1:1]);
            assign den_in  = in_den;
            assign q_in    = '0;
            assign side_in = in_side;
            assign nbit    = in_mag[0];
        end
        else
        begin : g_next
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign side_in = side_reg[k-1];
            assign nbit    = 1'b0;
        end

        assign t        = {rem_in, nbit};
        assign diff     = t - {1'b0, den_in};
        assign ge       = (t >= {1'b0, den_in});
        assign rem_next = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        assign q_next   = {q_in[Q_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                q_reg[k]    <= q_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_v    = v_reg[Q_W-1];
    assign out_q    = q_reg[Q_W-1];
    assign out_side = side_reg[Q_W-1];

endmodule

FILE: bench/three_body_gravity_acceleration_tb.sv
// ----------------------------------------------------------------------------
// three_body_gravity_acceleration_tb
// Streams body triples through the acceleration pipeline and checks every
// output item against an exact fixed-point predictor. Both handshakes are
// throttled, including one long output hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module three_body_gravity_acceleration_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WB        = 32;
    localparam int LATENCY   = 90;
    localparam int N_RANDOM  = 900;
    localparam int CYC_LIMIT = 400000;

    typedef struct packed {
        logic signed [tbga_pkg::POS_W-1:0] x1, y1, x2, y2, x3, y3;
    } triple_t;

    typedef struct packed {
        logic signed [tbga_pkg::POS_W-1:0] ax1, ay1, ax2, ay2, ax3, ay3;
        logic                              coin, sat;
    } accel_t;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [tbga_pkg::POS_W-1:0] pos_x1, pos_y1, pos_x2, pos_y2, pos_x3, pos_y3;
    logic signed [tbga_pkg::POS_W-1:0] acc_x1, acc_y1, acc_x2, acc_y2, acc_x3, acc_y3;
    logic coincident, saturated;

    triple_t pending_triples[$];
    accel_t  expected_accels[$];
    bit      stim_done;
    bit      accepted;
    int      errors;
    int      results_seen;
    int      cycles;

    three_body_gravity_acceleration #(.WORD_BITS(WB)) u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // --- predictor -----------------------------------------------------------
    function automatic logic [127:0] isqrt(logic [127:0] s);
        logic [127:0] r, c;
        r = '0;
        for (int b = 33; b >= 0; b--)
        begin
            c = r | (128'd1 << b);
            if (c * c <= s)
                r = c;
        end
        return r;
    endfunction

    function automatic longint pull_term(longint d, logic [127:0] s, logic [127:0] r);
        logic [127:0] num, den, q;
        longint mag;
        if (d == 0)
            return 0;
        mag = (d < 0) ? -d : d;
        num = 128'(mag) << tbga_pkg::FRAC_SH;
        den = s * r;
        q   = num / den;
        return (d < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic logic [127:0] dist_sq(longint dx, longint dy);
        logic [127:0] ax, ay;
        ax = 128'((dx < 0) ? -dx : dx);
        ay = 128'((dy < 0) ? -dy : dy);
        return ax * ax + ay * ay;
    endfunction

    function automatic logic [31:0] clamp(longint v, inout logic sat);
        longint hi, lo;
        hi = (longint'(1) <<< (WB - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            sat = 1'b1;
            return hi[31:0];
        end
        if (v < lo)
        begin
            sat = 1'b1;
            return lo[31:0];
        end
        return v[31:0];
    endfunction

    function automatic accel_t predict_accel(triple_t t);
        accel_t       a;
        longint       dx12, dy12, dx13, dy13, dx23, dy23;
        longint       t12x, t12y, t13x, t13y, t23x, t23y;
        logic [127:0] s12, s13, s23, r12, r13, r23;
        logic         sat;
        dx12 = longint'(t.x2) - longint'(t.x1);
        dy12 = longint'(t.y2) - longint'(t.y1);
        dx13 = longint'(t.x3) - longint'(t.x1);
        dy13 = longint'(t.y3) - longint'(t.y1);
        dx23 = longint'(t.x3) - longint'(t.x2);
        dy23 = longint'(t.y3) - longint'(t.y2);
        s12 = dist_sq(dx12, dy12);
        s13 = dist_sq(dx13, dy13);
        s23 = dist_sq(dx23, dy23);
        a   = '0;
        sat = 1'b0;
        a.coin = (s12 == 0) || (s13 == 0) || (s23 == 0);
        if (!a.coin)
        begin
            r12 = isqrt(s12);
            r13 = isqrt(s13);
            r23 = isqrt(s23);
            t12x = pull_term(dx12, s12, r12);
            t12y = pull_term(dy12, s12, r12);
            t13x = pull_term(dx13, s13, r13);
            t13y = pull_term(dy13, s13, r13);
            t23x = pull_term(dx23, s23, r23);
            t23y = pull_term(dy23, s23, r23);
            a.ax1 = clamp(t12x + t13x, sat);
            a.ay1 = clamp(t12y + t13y, sat);
            a.ax2 = clamp(-t12x + t23x, sat);
            a.ay2 = clamp(-t12y + t23y, sat);
            a.ax3 = clamp(-t13x - t23x, sat);
            a.ay3 = clamp(-t13y - t23y, sat);
        end
        a.sat = sat;
        return a;
    endfunction

    // --- stimulus ------------------------------------------------------------
    function automatic logic [31:0] near(logic [31:0] c);
        int sh;
        sh = $urandom_range(0, 24);
        return c + (($urandom() >> (31 - sh)) - (32'd1 << sh));
    endfunction

    task automatic add(logic [31:0] a, b, c, d, e, f);
        triple_t t;
        t = {a, b, c, d, e, f};
        pending_triples.push_back(t);
    endtask

    initial
    begin
        logic [31:0] cx, cy;
        int kind;
        stim_done = 1'b0;
        add(0, 0, 0, 0, 0, 0);                                  // all coincide
        add(0, 0, 32'h0001_0000, 0, 0, 0);                      // bodies one and three share
        add(0, 0, 32'h0001_0000, 0, 32'h0002_0000, 32'h0001_0000);
        add(0, 0, 1, 0, 0, 1);                                  // one LSB apart, clips
        add(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h8000_0000, 32'h7fff_ffff);                      // extreme corners, far
        add(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
            32'hffff_ffff, 32'hffff_ffff);
        add(32'hffff_ffff, 0, 0, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000);
        add(0, 0, 32'h0001_0000, 32'h0001_0000, 32'hffff_0000, 32'h0001_0000);
        add(0, 32'h0001_0000, 0, 32'hffff_0000, 32'h0003_0000, 0); // zero components
        add(32'h0010_0000, 0, 32'h0010_0001, 0, 32'h0010_0000, 1);
        add(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_ffff,
            32'h7fff_ffff, 32'h7fff_fffe);
        add(32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0001);
        add(0, 0, 32'h0000_0100, 0, 32'h0000_0080, 32'h0000_00dd);
        add(32'h1234_5678, 32'h9abc_def0, 32'h1234_5678, 32'h9abc_def0,
            32'h0, 32'h1);                                      // one and two share
        for (int i = 0; i < N_RANDOM; i++)
        begin
            kind = $urandom_range(0, 9);
            cx = $urandom();
            cy = $urandom();
            if (kind < 2)
                add($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            else if (kind == 2)
                add(cx, cy, cx, cy, near(cx), near(cy));
            else
                add(near(cx), near(cy), near(cx), near(cy), near(cx), near(cy));
        end
        stim_done = 1'b1;
    end

    // --- reset, driver -------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_ready = 1'b0;
        {pos_x1, pos_y1, pos_x2, pos_y2, pos_x3, pos_y3} = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
    end

    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        triple_t t;
        if (rst_n && (!in_valid || accepted))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_triples.size() > 0)
            begin
                t = pending_triples.pop_front();
                {pos_x1, pos_y1, pos_x2, pos_y2, pos_x3, pos_y3} <= t;
                in_valid <= 1'b1;
                if (burst_left <= 0)
                    burst_left = $urandom_range(1, 40);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // --- receiver ------------------------------------------------------------
    int ready_mode  = 0;
    int mode_left   = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && results_seen >= 150)
            begin
                hold_done = 1'b1;
                hold_left = 400;     // long hold-off, well past the pipeline depth
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    ready_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(20, 200);
                end
                mode_left--;
                case (ready_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= $urandom_range(0, 1);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // --- monitor -------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        accel_t e;
        triple_t t;
        accepted <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            t = {pos_x1, pos_y1, pos_x2, pos_y2, pos_x3, pos_y3};
            expected_accels.push_back(predict_accel(t));
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_accels.size() == 0)
            begin
                $error("output item with no expectation pending");
                errors++;
            end
            else
            begin
                e = expected_accels.pop_front();
                check_field("acc_x1", e.ax1, acc_x1);
                check_field("acc_y1", e.ay1, acc_y1);
                check_field("acc_x2", e.ax2, acc_x2);
                check_field("acc_y2", e.ay2, acc_y2);
                check_field("acc_x3", e.ax3, acc_x3);
                check_field("acc_y3", e.ay3, acc_y3);
                check_field("coincident", e.coin, coincident);
                check_field("saturated", e.sat, saturated);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYC_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // --- end of run ----------------------------------------------------------
    initial
    begin
        errors       = 0;
        results_seen = 0;
        cycles       = 0;
        wait (rst_n);
        wait (stim_done && pending_triples.size() == 0);
        @(posedge clk);
        while (in_valid || expected_accels.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0 && expected_accels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: three_body_gravity_acceleration.f
sv/tbga_pkg.sv
sv/tbga_front.sv
sv/tbga_isqrt.sv
sv/tbga_cube.sv
sv/tbga_div.sv
sv/three_body_gravity_acceleration.sv
bench/three_body_gravity_acceleration_tb.sv
